// ===== hdl/sfr_pkg.sv =====
package sfr_pkg;

	localparam logic [7:0]  START_BYTE = 8'hA5;
	localparam logic [7:0]  END_BYTE   = 8'h5A;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [15:0] LEN_LIMIT  = 16'd65532;
	localparam logic [15:0] LEN_MIN    = 16'd3;

	localparam logic [1:0] CFG_OWN   = 2'd0;
	localparam logic [1:0] CFG_HOST  = 2'd1;
	localparam logic [1:0] CFG_BCAST = 2'd2;
	localparam logic [1:0] CFG_MAXLEN = 2'd3;

	typedef enum logic [3:0] {
		PH_HUNT, PH_SRC, PH_DST, PH_FN0, PH_FN1, PH_LEN0, PH_LEN1,
		PH_CMD0, PH_CMD1, PH_DATA, PH_ACK, PH_CRC0, PH_CRC1, PH_END
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PAYLOAD = 3'd0,
		KIND_ACCEPT  = 3'd1,
		KIND_CRC_ERR = 3'd2,
		KIND_END_ERR = 3'd3,
		KIND_LEN_ERR = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0]  own_address;
		logic [7:0]  host_address;
		logic [7:0]  broadcast_address;
		logic [15:0] max_length;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [7:0]  source;
		logic [7:0]  destination;
		logic [15:0] frame_number;
		logic [15:0] command;
		logic [15:0] payload_length;
		logic        ack_req;
		logic        address_match;
	} result_t;

	// CRC-16/MODBUS, one byte, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/sfr_parser.sv =====
module sfr_parser import sfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output logic       res_valid,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic [15:0] remain_q, remain_d;
	logic [15:0] len_q, len_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  src_q, src_d;
	logic [7:0]  dst_q, dst_d;
	logic [15:0] fn_q, fn_d;
	logic [15:0] cmd_q, cmd_d;
	logic        ack_q, ack_d;
	logic [15:0] rcrc_q, rcrc_d;

	logic [15:0] len_full;
	logic [15:0] lim;
	logic [15:0] crc_next;
	logic        feed_crc;

	assign len_full = {rx_byte, len_q[7:0]};
	assign lim      = (cfg.max_length > LEN_LIMIT) ? LEN_LIMIT : cfg.max_length;
	assign crc_next = crc16_byte(crc_q, rx_byte);

	always_comb begin
		phase_d   = phase_q;
		remain_d  = remain_q;
		len_d     = len_q;
		src_d     = src_q;
		dst_d     = dst_q;
		fn_d      = fn_q;
		cmd_d     = cmd_q;
		ack_d     = ack_q;
		rcrc_d    = rcrc_q;
		feed_crc  = 1'b1;
		res_valid = 1'b0;
		res       = '0;
		res.kind  = KIND_PAYLOAD;
		case (phase_q)
			PH_HUNT: begin
				feed_crc = 1'b0;
				if (rx_byte == START_BYTE) begin
					phase_d = PH_SRC;
				end
			end
			PH_SRC: begin
				src_d   = rx_byte;
				phase_d = PH_DST;
			end
			PH_DST: begin
				dst_d   = rx_byte;
				phase_d = PH_FN0;
			end
			PH_FN0: begin
				fn_d    = {8'h00, rx_byte};
				phase_d = PH_FN1;
			end
			PH_FN1: begin
				fn_d    = {rx_byte, fn_q[7:0]};
				phase_d = PH_LEN0;
			end
			PH_LEN0: begin
				len_d   = {8'h00, rx_byte};
				phase_d = PH_LEN1;
			end
			PH_LEN1: begin
				len_d = len_full;
				if (len_full < LEN_MIN || len_full > lim) begin
					feed_crc  = 1'b0;
					phase_d   = PH_HUNT;
					res_valid = 1'b1;
					res.kind  = KIND_LEN_ERR;
				end else begin
					remain_d = len_full - LEN_MIN;
					phase_d  = PH_CMD0;
				end
			end
			PH_CMD0: begin
				cmd_d   = {8'h00, rx_byte};
				phase_d = PH_CMD1;
			end
			PH_CMD1: begin
				cmd_d   = {rx_byte, cmd_q[7:0]};
				phase_d = (remain_q != 16'd0) ? PH_DATA : PH_ACK;
			end
			PH_DATA: begin
				remain_d = remain_q - 16'd1;
				if (remain_q == 16'd1) begin
					phase_d = PH_ACK;
				end
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = rx_byte;
			end
			PH_ACK: begin
				ack_d   = (rx_byte != 8'h00);
				phase_d = PH_CRC0;
			end
			PH_CRC0: begin
				feed_crc = 1'b0;
				rcrc_d   = {8'h00, rx_byte};
				phase_d  = PH_CRC1;
			end
			PH_CRC1: begin
				feed_crc = 1'b0;
				rcrc_d   = {rx_byte, rcrc_q[7:0]};
				phase_d  = PH_END;
			end
			PH_END: begin
				feed_crc  = 1'b0;
				phase_d   = PH_HUNT;
				res_valid = 1'b1;
				if (rx_byte != END_BYTE) begin
					res.kind = KIND_END_ERR;
				end else if (rcrc_q != crc_q) begin
					res.kind = KIND_CRC_ERR;
				end else begin
					res.kind           = KIND_ACCEPT;
					res.source         = src_q;
					res.destination    = dst_q;
					res.frame_number   = fn_q;
					res.command        = cmd_q;
					res.payload_length = len_q - LEN_MIN;
					res.ack_req        = ack_q;
					res.address_match  = (dst_q == cfg.own_address) ||
						(dst_q == cfg.host_address) || (dst_q == cfg.broadcast_address);
				end
			end
			default: begin
				feed_crc = 1'b0;
				phase_d  = PH_HUNT;
			end
		endcase
	end

	always_comb begin
		crc_d = crc_q;
		if (phase_q == PH_HUNT) begin
			crc_d = CRC_INIT;
		end else if (feed_crc) begin
			crc_d = crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			remain_q <= '0;
			len_q    <= '0;
			crc_q    <= CRC_INIT;
			src_q    <= '0;
			dst_q    <= '0;
			fn_q     <= '0;
			cmd_q    <= '0;
			ack_q    <= 1'b0;
			rcrc_q   <= '0;
		end else if (en) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			len_q    <= len_d;
			crc_q    <= crc_d;
			src_q    <= src_d;
			dst_q    <= dst_d;
			fn_q     <= fn_d;
			cmd_q    <= cmd_d;
			ack_q    <= ack_d;
			rcrc_q   <= rcrc_d;
		end
	end

endmodule

// ===== hdl/sfr_out_reg.sv =====
module sfr_out_reg import sfr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    out_ready,
	output logic    room,
	output logic    out_valid,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	assign room      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== hdl/serial_frame_receiver_crc16.sv =====
// A byte passes through the input register, then its result is loaded into the result register.
// Throughput: one byte per cycle; the byte-wide CRC step and frame parser sit in one stage.
// Back-pressure stalls the input register only when a byte yields a result and the
// result register is full and out_ready is low.
// Reset: asynchronous, active low; parser hunts for start byte, CRC = 0xFFFF,
// address and length registers take their defaults.
module serial_frame_receiver_crc16 import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  source,
	output logic [7:0]  destination,
	output logic [15:0] frame_number,
	output logic [15:0] command,
	output logic [15:0] payload_length,
	output logic        ack_req,
	output logic        address_match,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t    cfg_q;
	logic    s1_valid_q;
	logic [7:0] rx_byte_s1;
	logic    en;
	logic    res_valid;
	result_t res;
	result_t res_out;
	logic    room;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address       <= 8'd1;
			cfg_q.host_address      <= 8'd128;
			cfg_q.broadcast_address <= 8'd255;
			cfg_q.max_length        <= LEN_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OWN:    cfg_q.own_address       <= cfg_data[7:0];
				CFG_HOST:   cfg_q.host_address      <= cfg_data[7:0];
				CFG_BCAST:  cfg_q.broadcast_address <= cfg_data[7:0];
				CFG_MAXLEN: cfg_q.max_length        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = s1_valid_q && (!res_valid || room);
	assign in_ready = !s1_valid_q || en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	sfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.rx_byte   (rx_byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	sfr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (en && res_valid),
		.res_in    (res),
		.out_ready (out_ready),
		.room      (room),
		.out_valid (out_valid),
		.res_out   (res_out)
	);

	assign kind           = res_out.kind;
	assign payload_byte   = res_out.payload_byte;
	assign source         = res_out.source;
	assign destination    = res_out.destination;
	assign frame_number   = res_out.frame_number;
	assign command        = res_out.command;
	assign payload_length = res_out.payload_length;
	assign ack_req        = res_out.ack_req;
	assign address_match  = res_out.address_match;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !(en && res_valid))
		else $error("result register overwritten while full");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !en) |=> (s1_valid_q && $stable(rx_byte_s1)))
		else $error("input register lost a stalled byte");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res_out.kind != KIND_ACCEPT) |->
		(source == 8'd0 && destination == 8'd0 && frame_number == 16'd0 &&
		command == 16'd0 && payload_length == 16'd0 && !ack_req && !address_match))
		else $error("header fields set on a non-accept result");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res_out.kind != KIND_PAYLOAD) |-> (payload_byte == 8'd0))
		else $error("payload byte set on a frame status result");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import sfr_pkg::*;

	typedef enum {FLAW_NONE, FLAW_CRC, FLAW_END, FLAW_LEN} frame_flaw_t;

	typedef struct {
		logic [7:0] b;
		bit typed;
		kind_t want_kind;
	} feed_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_ready;
	logic [2:0] kind;
	logic [7:0] payload_byte;
	logic [7:0] source;
	logic [7:0] destination;
	logic [15:0] frame_number;
	logic [15:0] command;
	logic [15:0] payload_length;
	logic ack_req;
	logic address_match;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	serial_frame_receiver_crc16 u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// frame parser mirror
	cfg_t node_cfg = '{8'd1, 8'd128, 8'd255, LEN_LIMIT};
	phase_t frame_phase = PH_HUNT;
	logic [16:0] data_left = '0;
	logic [15:0] len_field = '0;
	logic [15:0] crc_acc = CRC_INIT;
	logic [15:0] crc_rx = '0;
	logic [15:0] fn_q = '0;
	logic [15:0] cmd_q = '0;
	logic [7:0] src_q = '0;
	logic [7:0] dst_q = '0;
	logic ack_q = 1'b0;

	feed_t feed_q[$];
	feed_t on_wire;
	result_t results_due[$];
	bit calm = 1'b0;
	int bytes_fed = 0;
	int bad_results = 0;
	int kind_seen[5] = '{0, 0, 0, 0, 0};

	// kind column only counts where typed is set
	feed_t directed_rows[29] = '{
		'{8'h00, 1'b0, KIND_PAYLOAD},
		'{8'hA5, 1'b0, KIND_PAYLOAD},
		'{8'hFF, 1'b0, KIND_PAYLOAD},
		'{8'h00, 1'b0, KIND_PAYLOAD},
		'{8'hFF, 1'b0, KIND_PAYLOAD},
		'{8'hFF, 1'b0, KIND_PAYLOAD},
		'{8'h02, 1'b0, KIND_PAYLOAD},
		'{8'h00, 1'b1, KIND_LEN_ERR},
		'{8'hA5, 1'b0, KIND_PAYLOAD},
		'{8'h00, 1'b0, KIND_PAYLOAD},
		'{8'hFF, 1'b0, KIND_PAYLOAD},
		'{8'h00, 1'b0, KIND_PAYLOAD},
		'{8'h00, 1'b0, KIND_PAYLOAD},
		'{8'hFD, 1'b0, KIND_PAYLOAD},
		'{8'hFF, 1'b1, KIND_LEN_ERR},
		'{8'hA5, 1'b0, KIND_PAYLOAD},
		'{8'h80, 1'b0, KIND_PAYLOAD},
		'{8'h01, 1'b0, KIND_PAYLOAD},
		'{8'h34, 1'b0, KIND_PAYLOAD},
		'{8'h12, 1'b0, KIND_PAYLOAD},
		'{8'h04, 1'b0, KIND_PAYLOAD},
		'{8'h00, 1'b0, KIND_PAYLOAD},
		'{8'hFF, 1'b0, KIND_PAYLOAD},
		'{8'hFF, 1'b0, KIND_PAYLOAD},
		'{8'hA5, 1'b1, KIND_PAYLOAD},
		'{8'h01, 1'b0, KIND_PAYLOAD},
		'{8'h00, 1'b0, KIND_PAYLOAD},
		'{8'h00, 1'b0, KIND_PAYLOAD},
		'{8'hA5, 1'b1, KIND_END_ERR}
	};

	function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] c;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[i]) begin
				c = {1'b0, c[15:1]} ^ CRC_POLY;
			end else begin
				c = {1'b0, c[15:1]};
			end
		end
		return c;
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		logic [15:0] lim;
		r = '0;
		lim = (node_cfg.max_length > LEN_LIMIT) ? LEN_LIMIT : node_cfg.max_length;
		case (frame_phase)
			PH_HUNT: begin
				if (b == START_BYTE) begin
					crc_acc = CRC_INIT;
					frame_phase = PH_SRC;
				end
				return 1'b0;
			end
			PH_SRC: begin
				src_q = b;
				frame_phase = PH_DST;
			end
			PH_DST: begin
				dst_q = b;
				frame_phase = PH_FN0;
			end
			PH_FN0: begin
				fn_q = {8'h00, b};
				frame_phase = PH_FN1;
			end
			PH_FN1: begin
				fn_q[15:8] = b;
				frame_phase = PH_LEN0;
			end
			PH_LEN0: begin
				len_field = {8'h00, b};
				frame_phase = PH_LEN1;
			end
			PH_LEN1: begin
				len_field[15:8] = b;
				if (len_field < LEN_MIN || len_field > lim) begin
					frame_phase = PH_HUNT;
					r.kind = KIND_LEN_ERR;
					return 1'b1;
				end
				data_left = {1'b0, len_field - LEN_MIN};
				frame_phase = PH_CMD0;
			end
			PH_CMD0: begin
				cmd_q = {8'h00, b};
				frame_phase = PH_CMD1;
			end
			PH_CMD1: begin
				cmd_q[15:8] = b;
				frame_phase = (data_left != '0) ? PH_DATA : PH_ACK;
			end
			PH_DATA: begin
				crc_acc = modbus_crc_step(crc_acc, b);
				data_left = data_left - 17'd1;
				if (data_left == '0) begin
					frame_phase = PH_ACK;
				end
				r.kind = KIND_PAYLOAD;
				r.payload_byte = b;
				return 1'b1;
			end
			PH_ACK: begin
				ack_q = (b != 8'h00);
				frame_phase = PH_CRC0;
			end
			PH_CRC0: begin
				crc_rx = {8'h00, b};
				frame_phase = PH_CRC1;
				return 1'b0;
			end
			PH_CRC1: begin
				crc_rx[15:8] = b;
				frame_phase = PH_END;
				return 1'b0;
			end
			PH_END: begin
				frame_phase = PH_HUNT;
				if (b != END_BYTE) begin
					r.kind = KIND_END_ERR;
				end else if (crc_rx != crc_acc) begin
					r.kind = KIND_CRC_ERR;
				end else begin
					r.kind = KIND_ACCEPT;
					r.source = src_q;
					r.destination = dst_q;
					r.frame_number = fn_q;
					r.command = cmd_q;
					r.payload_length = len_field - LEN_MIN;
					r.ack_req = ack_q;
					r.address_match = (dst_q == node_cfg.own_address) ||
						(dst_q == node_cfg.host_address) ||
						(dst_q == node_cfg.broadcast_address);
				end
				return 1'b1;
			end
			default: begin
				frame_phase = PH_HUNT;
				return 1'b0;
			end
		endcase
		// source through ack flag feed the CRC
		crc_acc = modbus_crc_step(crc_acc, b);
		return 1'b0;
	endfunction

	function automatic string result_text(input result_t r);
		return $sformatf("kind %0d byte %h src %h dst %h frame %h cmd %h len %0d ack %b match %b",
			r.kind, r.payload_byte, r.source, r.destination, r.frame_number, r.command,
			r.payload_length, r.ack_req, r.address_match);
	endfunction

	// byte requests
	always @(posedge clk) begin
		result_t outcome;
		bit has_result;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				bytes_fed++;
				has_result = deframe_byte(rx_byte, outcome);
				if (on_wire.typed) begin
					outcome = '0;
					outcome.kind = on_wire.want_kind;
					if (on_wire.want_kind == KIND_PAYLOAD) begin
						outcome.payload_byte = on_wire.b;
					end
					has_result = 1'b1;
				end
				if (has_result) begin
					results_due.push_back(outcome);
				end
			end
			if (!in_valid || in_ready) begin
				if (feed_q.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
					on_wire = feed_q.pop_front();
					rx_byte <= on_wire.b;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result requests
	always @(posedge clk) begin
		result_t seen;
		result_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen = '{kind_t'(kind), payload_byte, source, destination, frame_number,
					command, payload_length, ack_req, address_match};
				if (results_due.size() == 0) begin
					bad_results++;
					if (bad_results <= 10) begin
						$display("%0t: result with none due: %s", $time, result_text(seen));
					end
				end else begin
					due = results_due.pop_front();
					kind_seen[due.kind]++;
					if (seen.kind !== due.kind || seen.payload_byte !== due.payload_byte ||
						seen.source !== due.source || seen.destination !== due.destination ||
						seen.frame_number !== due.frame_number || seen.command !== due.command ||
						seen.payload_length !== due.payload_length ||
						seen.ack_req !== due.ack_req ||
						seen.address_match !== due.address_match) begin
						bad_results++;
						if (bad_results <= 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected %s", result_text(due));
							$display("  actual   %s", result_text(seen));
						end
					end
				end
			end
			out_ready <= calm || ($urandom_range(99) >= 23);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		feed_q.push_back('{b, 1'b0, KIND_PAYLOAD});
	endtask

	// n_data < 0 picks a random payload size, or a random bad length with FLAW_LEN
	task automatic queue_frame(input logic [15:0] lim, input int n_data, input frame_flaw_t flaw);
		logic [7:0] body[$];
		logic [15:0] len;
		logic [15:0] crc;
		logic [15:0] fn;
		logic [15:0] cmd;
		logic [7:0] dst;
		logic [7:0] end_b;
		int n;
		n = n_data;
		if (n < 0) begin
			if (lim < LEN_MIN) begin
				n = $urandom_range(4);
			end else if (lim - LEN_MIN <= 40 && $urandom_range(3) == 0) begin
				n = int'(lim - LEN_MIN);
			end else begin
				n = $urandom_range((lim - LEN_MIN < 8) ? lim - LEN_MIN : 8);
			end
		end
		len = 16'(n) + LEN_MIN;
		if (flaw == FLAW_LEN && n_data < 0) begin
			if (lim < LEN_MIN || $urandom_range(1)) begin
				len = 16'($urandom_range(2));
			end else if ($urandom_range(1)) begin
				len = lim + 16'd1;
			end else begin
				len = 16'($urandom_range(65535, lim + 1));
			end
		end
		case ($urandom_range(3))
			0: dst = node_cfg.own_address;
			1: dst = node_cfg.host_address;
			2: dst = node_cfg.broadcast_address;
			default: dst = 8'($urandom);
		endcase
		fn = 16'($urandom);
		cmd = 16'($urandom);
		body.push_back(8'($urandom));
		body.push_back(dst);
		body.push_back(fn[7:0]);
		body.push_back(fn[15:8]);
		body.push_back(len[7:0]);
		body.push_back(len[15:8]);
		push_byte(START_BYTE);
		if (flaw == FLAW_LEN) begin
			foreach (body[i]) push_byte(body[i]);
			return;
		end
		body.push_back(cmd[7:0]);
		body.push_back(cmd[15:8]);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(7) == 0) begin
				body.push_back($urandom_range(1) ? START_BYTE : END_BYTE);
			end else begin
				body.push_back(8'($urandom));
			end
		end
		body.push_back($urandom_range(1) ? 8'h00 : 8'($urandom));
		crc = CRC_INIT;
		foreach (body[i]) begin
			crc = modbus_crc_step(crc, body[i]);
			push_byte(body[i]);
		end
		if (flaw == FLAW_CRC) begin
			crc = crc ^ 16'($urandom_range(65535, 1));
		end
		end_b = END_BYTE;
		if (flaw == FLAW_END) begin
			do end_b = 8'($urandom); while (end_b == END_BYTE);
		end
		push_byte(crc[7:0]);
		push_byte(crc[15:8]);
		push_byte(end_b);
	endtask

	task automatic random_phase(input int unsigned byte_budget);
		logic [15:0] lim;
		logic [7:0] nb;
		int unsigned target;
		int unsigned pick;
		frame_flaw_t flaw;
		lim = (node_cfg.max_length > LEN_LIMIT) ? LEN_LIMIT : node_cfg.max_length;
		target = feed_q.size() + byte_budget;
		while (feed_q.size() < target) begin
			if ($urandom_range(99) < 8) begin
				do nb = 8'($urandom); while (nb == START_BYTE);
				push_byte(nb);
			end else begin
				pick = $urandom_range(99);
				flaw = (pick < 70) ? FLAW_NONE : (pick < 80) ? FLAW_CRC :
					(pick < 90) ? FLAW_END : FLAW_LEN;
				queue_frame(lim, -1, flaw);
			end
		end
	endtask

	task automatic set_regs(input logic [7:0] own, input logic [7:0] host,
		input logic [7:0] bcast, input logic [15:0] maxl);
		logic [1:0] idx[4];
		logic [15:0] val[4];
		idx = '{CFG_OWN, CFG_HOST, CFG_BCAST, CFG_MAXLEN};
		val = '{{8'($urandom), own}, {8'($urandom), host}, {8'($urandom), bcast}, maxl};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		node_cfg = '{own, host, bcast, maxl};
	endtask

	task automatic drain();
		do @(negedge clk); while (feed_q.size() != 0 || in_valid || results_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_OWN;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		foreach (directed_rows[i]) feed_q.push_back(directed_rows[i]);
		drain();

		// saturated limit, one past the limit
		set_regs(8'h3C, 8'h00, 8'hC3, 16'hFFFF);
		@(negedge clk);
		calm = 1'b1;
		queue_frame(LEN_LIMIT, LEN_LIMIT - LEN_MIN + 1, FLAW_LEN);
		random_phase(80);
		drain();

		set_regs(8'h00, 8'hFF, 8'h7E, LEN_MIN);
		@(negedge clk);
		calm = 1'b0;
		random_phase(70);
		drain();

		set_regs(8'($urandom), 8'($urandom), 8'($urandom), 16'd0);
		@(negedge clk);
		random_phase(40);
		drain();

		set_regs(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(40, 4)));
		@(negedge clk);
		random_phase(100);
		drain();

		set_regs(8'($urandom), 8'($urandom), 8'($urandom), LEN_LIMIT);
		@(negedge clk);
		queue_frame(LEN_LIMIT, LEN_LIMIT - LEN_MIN + 1, FLAW_LEN);
		random_phase(100);
		drain();

		if (results_due.size() != 0) begin
			$display("%0d expected results never came out", results_due.size());
		end
		$display("fed %0d bytes over five register settings plus reset defaults", bytes_fed);
		$display("checked %0d payload bytes, %0d good frames, %0d crc / %0d end / %0d length errors",
			kind_seen[KIND_PAYLOAD], kind_seen[KIND_ACCEPT], kind_seen[KIND_CRC_ERR],
			kind_seen[KIND_END_ERR], kind_seen[KIND_LEN_ERR]);
		if (bad_results == 0 && results_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("run did not finish in time");
		$display("FAIL");
		$finish;
	end

endmodule
